// ===== sv/bu2x_pkg.sv =====
// Shared constants, types and pixel arithmetic for the 2x bilinear upscaler.
`default_nettype none

package bu2x_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 16;
  localparam int FW_W       = 10;
  localparam int FH_W       = 11;
  localparam int X_W        = 10;
  localparam int Y_W        = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [PIX_W-1:0] MIX_MASK = 16'hF7DE;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 10'd256;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 11'd192;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Bit positions in the pending-result mask, in emission order.
  localparam int RES_DIAG   = 3;
  localparam int RES_VERT   = 2;
  localparam int RES_HORIZ  = 1;
  localparam int RES_CENTRE = 0;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] upper_left;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             frame_end;
  } hold_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic             run_last;
    logic             frame_end;
  } result_t;

  // Average all three channels at once: drop each channel's LSB, add, halve.
  function automatic logic [PIX_W-1:0] mix(input logic [PIX_W-1:0] a,
                                           input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a & MIX_MASK} + {1'b0, b & MIX_MASK};
    return s[PIX_W:1];
  endfunction

endpackage

`default_nettype wire

// ===== sv/bu2x_if.sv =====
// Stream interfaces for source pixels and upscaled result pixels.
`default_nettype none

interface bu2x_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface bu2x_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_pixel;
  logic [9:0]  out_x;
  logic [10:0] out_y;
  logic        run_last;
  logic        frame_end;

  modport source (output valid, output out_pixel, output out_x, output out_y,
                  output run_last, output frame_end, input ready);
  modport sink   (input valid, input out_pixel, input out_x, input out_y,
                  input run_last, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== sv/bu2x_emit.sv =====
// Result selector: picks the next pending output pixel of a held source pixel.
`default_nettype none

module bu2x_emit (
  input  bu2x_pkg::hold_t   held,
  input  logic [3:0]        pend,
  output bu2x_pkg::result_t res,
  output logic [3:0]        pend_next
);
  import bu2x_pkg::*;

  logic [PIX_W-1:0] hmid;
  logic [X_W-1:0]   x_even;
  logic [Y_W-1:0]   y_even;

  assign hmid   = mix(held.left, held.pixel);
  assign x_even = {held.col, 1'b0};
  assign y_even = {held.row, 1'b0};

  always_comb begin
    pend_next     = pend;
    res.pixel     = held.pixel;
    res.x         = x_even;
    res.y         = y_even;
    res.frame_end = held.frame_end;
    priority if (pend[RES_DIAG]) begin
      res.pixel          = mix(mix(held.upper_left, held.above), hmid);
      res.x              = x_even - X_W'(1);
      res.y              = y_even - Y_W'(1);
      pend_next[RES_DIAG] = 1'b0;
    end else if (pend[RES_VERT]) begin
      res.pixel          = mix(held.above, held.pixel);
      res.y              = y_even - Y_W'(1);
      pend_next[RES_VERT] = 1'b0;
    end else if (pend[RES_HORIZ]) begin
      res.pixel           = hmid;
      res.x               = x_even - X_W'(1);
      pend_next[RES_HORIZ] = 1'b0;
    end else begin
      pend_next[RES_CENTRE] = 1'b0;
    end
    res.run_last = (pend_next == 4'b0000);
  end

endmodule

`default_nettype wire

// ===== sv/bilinear_2x_upscaler_rgb565.sv =====
// Top level of the 2x bilinear RGB565 upscaler.
// Usage:
//   src carries RGB565 source pixels in raster order; a transfer happens when
//   valid and ready are both high. dst carries output pixels with their
//   output column and row, run_last on the final result of each source pixel
//   and frame_end on every result of the frame's last source pixel.
//   cfg_we/cfg_index/cfg_data write frame_width (index 0) and frame_height
//   (index 1); write them only while the block is idle.
// Timing:
//   A source pixel enters the hold stage on transfer, its results the output
//   register. Each source pixel gives one result per cycle, unless stalled,
//   on the single-pixel output register: 1 for the frame's top-left pixel,
//   2 on the first row or column, 4 elsewhere. A new source pixel is taken
//   in the cycle its predecessor's last result moves to the output register.
//   The line buffer read is prefetched for the next column, so no bubble.
// Reset: rst clears the counters, neighbour pixels and both pipeline stages;
//   sizes return to 256 x 192. The line buffer is not cleared.
// Stall: while dst.ready is low the output register holds, the held pixel
//   waits and src.ready drops once a source pixel is waiting.
`default_nettype none

module bilinear_2x_upscaler_rgb565 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bu2x_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bu2x_pkg::CFG_DATA_W-1:0]     cfg_data,
  bu2x_in_if.sink                             src,
  bu2x_out_if.source                          dst
);
  import bu2x_pkg::*;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [COL_W-1:0] column_count;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count;
  logic [ROW_W-1:0] row_count_next;
  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] upper_left_pixel;
  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] prev_row_store [MAX_WIDTH];

  hold_t            held;
  logic             hold_valid;
  logic [3:0]       pend;
  logic [3:0]       pend_next;
  result_t          res;
  result_t          out_reg;
  logic             out_valid;

  logic             in_xfer;
  logic             out_load;
  logic             last_col;
  logic             last_row;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // A count at or past size minus one, or at the hard limit, ends the run.
  assign last_col = ({1'b0, column_count} + FW_W'(1) >= frame_width)
                    || (column_count == COL_W'(MAX_WIDTH - 1));
  assign last_row = ({1'b0, row_count} + FH_W'(1) >= frame_height)
                    || (row_count == ROW_W'(MAX_HEIGHT - 1));

  assign out_load = hold_valid && (!out_valid || dst.ready);
  assign src.ready = !hold_valid || (out_load && res.run_last);
  assign in_xfer  = src.valid && src.ready;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (in_xfer) begin
      if (last_col) begin
        column_count_next = '0;
        row_count_next    = last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count_next = column_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_count        <= '0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (in_xfer) begin
        left_pixel       <= src.source_pixel;
        upper_left_pixel <= above;
      end
    end
  end

  // Line buffer: read ahead at the next column, forward a same-address write.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      prev_row_store[column_count] <= src.source_pixel;
    end
    if (in_xfer && (column_count_next == column_count)) begin
      above <= src.source_pixel;
    end else begin
      above <= prev_row_store[column_count_next];
    end
  end

  // Held source pixel and its pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pend       <= '0;
    end else if (in_xfer) begin
      hold_valid            <= 1'b1;
      pend[RES_DIAG]        <= (row_count != '0) && (column_count != '0);
      pend[RES_VERT]        <= (row_count != '0);
      pend[RES_HORIZ]       <= (column_count != '0);
      pend[RES_CENTRE]      <= 1'b1;
    end else if (out_load) begin
      hold_valid <= !res.run_last;
      pend       <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      held.pixel      <= src.source_pixel;
      held.above      <= above;
      held.left       <= left_pixel;
      held.upper_left <= upper_left_pixel;
      held.col        <= column_count;
      held.row        <= row_count;
      held.frame_end  <= last_col && last_row;
    end
  end

  bu2x_emit u_emit (
    .held      (held),
    .pend      (pend),
    .res       (res),
    .pend_next (pend_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= res;
    end
  end

  assign dst.valid     = out_valid;
  assign dst.out_pixel = out_reg.pixel;
  assign dst.out_x     = out_reg.x;
  assign dst.out_y     = out_reg.y;
  assign dst.run_last  = out_reg.run_last;
  assign dst.frame_end = out_reg.frame_end;

`ifndef SYNTHESIS
  a_hold_has_work: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (pend != 4'b0000))
    else $error("held pixel with no pending result");

  a_xfer_fills_hold: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (hold_valid && pend[RES_CENTRE]))
    else $error("transfer did not load the hold stage");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && last_col) |=> (column_count == '0))
    else $error("column counter failed to wrap");

  a_ready_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !out_load) |-> !src.ready)
    else $error("source accepted while hold stage busy");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/bilinear_2x_upscaler_rgb565_tb.sv =====
// Self-checking testbench for the 2x bilinear RGB565 upscaler.
module bilinear_2x_upscaler_rgb565_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bu2x_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_ITEMS   = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    logic [PIX_W-1:0]         pix;
    bit                       typed;
    result_t                  want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bu2x_in_if  src_if ();
  bu2x_out_if dst_if ();

  bilinear_2x_upscaler_rgb565 i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (src_if),
    .dst       (dst_if)
  );

  result_t   upscaled_q [$];
  stim_row_t rows [$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;
  result_t   got_res;
  result_t   want_res;

  // Own copy of the block's state
  logic [PIX_W-1:0] line_mem  [MAX_WIDTH];
  bit               line_seen [MAX_WIDTH];
  logic [PIX_W-1:0] left_px;
  logic [PIX_W-1:0] upleft_px;
  int               col_cnt;
  int               row_cnt;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [PIX_W-1:0] blend565(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    int sum;
    sum = int'(a & MIX_MASK) + int'(b & MIX_MASK);
    return PIX_W'(sum >> 1);
  endfunction

  function automatic int clamp_width(int w);
    if (w < 1) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  // Number of line buffer columns, from zero, that hold a written pixel
  function automatic int seen_prefix();
    int n;
    n = 0;
    while (n < MAX_WIDTH && line_seen[n]) n++;
    return n;
  endfunction

  function automatic void upscale_pixel(logic [PIX_W-1:0] s);
    result_t          res [4];
    int               n, k, w, h, c, r;
    logic [PIX_W-1:0] above, hmid;
    bit               end_col, end_frame;
    w = clamp_width(int'(width_reg));
    h = int'(height_reg);
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    c = col_cnt % MAX_WIDTH;
    r = row_cnt;
    if (r > 0 && !line_seen[c]) begin
      errors++;
      $display("%0t: line buffer column %0d read before any write", $time, c);
    end
    above = line_mem[c];
    hmid  = blend565(left_px, s);
    n = 0;
    if (r > 0 && c > 0) begin
      res[n] = '{blend565(blend565(upleft_px, above), hmid), X_W'(2*c-1), Y_W'(2*r-1),
                 1'b0, 1'b0};
      n++;
    end
    if (r > 0) begin
      res[n] = '{blend565(above, s), X_W'(2*c), Y_W'(2*r-1), 1'b0, 1'b0};
      n++;
    end
    if (c > 0) begin
      res[n] = '{hmid, X_W'(2*c-1), Y_W'(2*r), 1'b0, 1'b0};
      n++;
    end
    res[n] = '{s, X_W'(2*c), Y_W'(2*r), 1'b0, 1'b0};
    n++;
    end_col   = (c + 1 >= w);
    end_frame = end_col && (r + 1 >= h);
    res[n-1].run_last = 1'b1;
    for (k = 0; k < n; k++) begin
      res[k].frame_end = end_frame;
      upscaled_q.push_back(res[k]);
    end
    line_mem[c]  = s;
    line_seen[c] = 1'b1;
    upleft_px    = above;
    left_px      = s;
    if (end_col) begin
      col_cnt = 0;
      row_cnt = end_frame ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    return '{ROW_CFG, idx, d, '0, 1'b0, '0};
  endfunction

  function automatic stim_row_t pix_row(logic [PIX_W-1:0] p);
    return '{ROW_PIX, '0, '0, p, 1'b0, '0};
  endfunction

  // A source pixel at the top-left of a frame gives back only itself at (0,0)
  function automatic stim_row_t typed_row(logic [PIX_W-1:0] p, bit fend);
    return '{ROW_PIX, '0, '0, p, 1'b1, '{p, '0, '0, 1'b1, fend}};
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    src_if.valid <= 1'b0;
    while (upscaled_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == CFG_FRAME_WIDTH) width_reg = data[FW_W-1:0];
    else height_reg = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pix, bit typed, result_t want);
    int n0;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      src_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    src_if.valid        <= 1'b1;
    src_if.source_pixel <= pix;
    do @(posedge clk); while (!src_if.ready);
    n0 = upscaled_q.size();
    upscale_pixel(pix);
    if (typed) begin
      while (upscaled_q.size() > n0) void'(upscaled_q.pop_back());
      upscaled_q.push_back(want);
    end
  endtask

  // Output back-pressure in random bursts
  initial begin
    int hold;
    hold = 0;
    dst_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        dst_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 6);
        dst_if.ready <= 1'b0;
      end else begin
        dst_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && dst_if.valid && dst_if.ready) begin
      got_res = '{dst_if.out_pixel, dst_if.out_x, dst_if.out_y, dst_if.run_last,
                  dst_if.frame_end};
      if (upscaled_q.size() == 0) begin
        errors++;
        $display("%0t: expected nothing, got pixel %h x %0d y %0d last %b end %b", $time,
                 got_res.pixel, got_res.x, got_res.y, got_res.run_last, got_res.frame_end);
      end else begin
        want_res = upscaled_q.pop_front();
        if (got_res !== want_res) begin
          errors++;
          $display("%0t: expected pixel %h x %0d y %0d last %b end %b,", $time,
                   want_res.pixel, want_res.x, want_res.y, want_res.run_last,
                   want_res.frame_end, " got pixel %h x %0d y %0d last %b end %b",
                   got_res.pixel, got_res.x, got_res.y, got_res.run_last,
                   got_res.frame_end);
        end
      end
    end
  end

  // Abort when neither side completes a transfer for too long
  always @(posedge clk) begin
    if (rst || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int                    sent;
    int                    burst;
    int                    wsel;
    int                    w;
    logic [CFG_DATA_W-1:0] d;
    logic [PIX_W-1:0]      pix;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    src_if.valid        = 1'b0;
    src_if.source_pixel = '0;
    width_reg  = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    left_px    = '0;
    upleft_px  = '0;
    col_cnt    = 0;
    row_cnt    = 0;
    foreach (line_seen[i]) line_seen[i] = 1'b0;

    rows = '{
      typed_row(16'hFFFF, 1'b0), pix_row(16'h0000),
      // shrink mid-row, then finish a 3x2 frame
      cfg_row(CFG_FRAME_WIDTH, 11'd3), cfg_row(CFG_FRAME_HEIGHT, 11'd2),
      pix_row(16'h1234), pix_row(16'hF800), pix_row(16'h07E0), pix_row(16'h001F),
      cfg_row(CFG_FRAME_WIDTH, 11'd1), cfg_row(CFG_FRAME_HEIGHT, 11'd1),
      typed_row(16'hFFFF, 1'b1), typed_row(16'h0000, 1'b1),
      typed_row(16'h8410, 1'b1), typed_row(16'h7BEF, 1'b1),
      // zero sizes clamp to one
      cfg_row(CFG_FRAME_WIDTH, 11'd0), cfg_row(CFG_FRAME_HEIGHT, 11'd0),
      typed_row(16'hAAAA, 1'b1), typed_row(16'h5555, 1'b1),
      // oversize clamps to the maximum
      cfg_row(CFG_FRAME_WIDTH, 11'h7FF), cfg_row(CFG_FRAME_HEIGHT, 11'h7FF),
      pix_row(16'hFFFF), pix_row(16'hFFFF), pix_row(16'h0001),
      // column count already past the new width: wrap after the next pixel
      cfg_row(CFG_FRAME_WIDTH, 11'd2), cfg_row(CFG_FRAME_HEIGHT, 11'd3),
      pix_row(16'hC618), pix_row(16'hFFFF), pix_row(16'h0000),
      pix_row(16'h0821), pix_row(16'hF7DE)
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
      else send_pixel(rows[i].pix, rows[i].typed, rows[i].want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wsel = $urandom_range(0, 2);
      if (wsel != 1) begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       w = 0;
            1:       w = 1;
            2:       w = MAX_WIDTH;
            default: w = 1023;
          endcase
        end else begin
          w = $urandom_range(1, 8);
        end
        d = {1'($urandom_range(0, 1)), FW_W'(w)};
        // widen only where every column the next rows read has been written
        if (row_cnt == 0 || clamp_width(w) <= seen_prefix()) write_reg(CFG_FRAME_WIDTH, d);
      end
      if (wsel != 0) begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       d = 11'd0;
            1:       d = 11'd1;
            2:       d = 11'(MAX_HEIGHT);
            default: d = 11'h7FF;
          endcase
        end else begin
          d = 11'($urandom_range(1, 5));
        end
        write_reg(CFG_FRAME_HEIGHT, d);
      end
      burst = $urandom_range(4, 40);
      repeat (burst) begin
        case ($urandom_range(0, 7))
          0:       pix = 16'h0000;
          1:       pix = 16'hFFFF;
          default: pix = 16'($urandom());
        endcase
        send_pixel(pix, 1'b0, '0);
        sent++;
        if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      end
    end

    @(negedge clk);
    src_if.valid <= 1'b0;
    while (upscaled_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bu2x_pkg.sv
sv/bu2x_if.sv
sv/bu2x_emit.sv
sv/bilinear_2x_upscaler_rgb565.sv
tb/sv/bilinear_2x_upscaler_rgb565_tb.sv
